[design/tmac_pkg.sv]
// Shared types, constants and load/feed helpers for the TRIAD-MAC tag engine.
`timescale 1ns / 1ps

package tmac_pkg;

  localparam int PERM_ROUNDS_DEF = 1024;
  localparam int LEN_BYTES_DEF   = 7;

  localparam int REG_A_W    = 80;
  localparam int REG_BC_W   = 88;
  localparam int KEY_HALF_W = 64;
  localparam int NONCE_HI_W = 32;
  localparam int TAG_W      = 64;
  localparam int COUNT_W    = 56;
  localparam int FEED_W     = 64;
  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_AD  = 2'd0,
    FUNC_MSG = 2'd1,
    FUNC_FIN = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_NONCE_LOW  = 2'd2,
    CFG_NONCE_HIGH = 2'd3
  } cfg_idx_t;

  // Source of the input bit for one register update.
  typedef enum logic [1:0] {
    M_ZERO = 2'd0,
    M_ONE  = 2'd1,
    M_FEED = 2'd2
  } msel_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ERR  = 2'd1,
    RES_TAG  = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AD   = 2'd1,
    PH_MSG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic  byte_ld;
    logic  load;
    logic  step;
    msel_t m_sel;
    logic  feed_byte;
    logic  feed_len;
    logic  sqz;
    logic  cnt_inc;
    logic  cnt_clr;
    logic  out_ld;
    res_t  res_kind;
  } tmac_cmd_t;

  // Byte k, bit j lands at register position 8k+8-j (vector bit 8k+7-j).
  function automatic logic [REG_A_W-1:0] reg_a_from_bytes(input logic [REG_A_W-1:0] bytes);
    logic [REG_A_W-1:0] r;
    r = '0;
    for (int k = 0; k < REG_A_W / 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        r[8*k + 7 - j] = bytes[8*k + j];
      end
    end
    return r;
  endfunction

  function automatic logic [REG_BC_W-1:0] reg_bc_from_bytes(input logic [REG_BC_W-1:0] bytes);
    logic [REG_BC_W-1:0] r;
    r = '0;
    for (int k = 0; k < REG_BC_W / 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        r[8*k + 7 - j] = bytes[8*k + j];
      end
    end
    return r;
  endfunction

  // Little-endian length bytes, each fed most significant bit first from bit 63.
  function automatic logic [FEED_W-1:0] feed_from_count(input logic [COUNT_W-1:0] cnt);
    logic [FEED_W-1:0] w;
    logic [FEED_W-1:0] f;
    w = {{(FEED_W-COUNT_W){1'b0}}, cnt};
    f = '0;
    for (int k = 0; k < FEED_W / 8; k++) begin
      f[FEED_W-1-8*k -: 8] = w[8*k +: 8];
    end
    return f;
  endfunction

endpackage

[design/triad_mac_tag_engine_top.sv]
// Top level of the TRIAD-MAC tag engine: controller plus datapath.
`timescale 1ns / 1ps

// TRIAD-MAC tag engine. Each accepted request (func 0 associated data byte,
// 1 message byte, 2 finish) yields exactly one result. Program key and nonce
// through the cfg port while the engine is idle; they are sampled when the
// first request of a message loads the three shift registers. The datapath
// performs one nonlinear register update per clock, so timing follows the
// update count: a byte request runs dispatch, one update per bit, the result
// write and idle again before the next accept. The first request of a
// message adds a load step and the pre-permutation. The first message byte
// or finish of a message also absorbs the length bytes and dispatches again.
// Finish runs the final permutation and the tag squeeze after dispatch, then
// the result write. Late associated data (after message bytes) returns
// error=1 and changes no state; func 3 returns an all-zero result likewise.
// A finished result waits in the output register; the next request is
// accepted meanwhile and holds in the result-write step only if the previous
// result is still stalled.
module triad_mac_tag_engine_top
  import tmac_pkg::*;
#(
  parameter int PERM_ROUNDS = PERM_ROUNDS_DEF,
  parameter int LEN_BYTES   = LEN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [BYTE_W-1:0]     in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TAG_W-1:0]      out_tag,
  output logic                  out_tag_valid,
  output logic                  out_error
);

  tmac_cmd_t cmd;

  // Sequencer: decodes the request, counts updates, owns the phase.
  tmac_ctrl #(
    .PERM_ROUNDS (PERM_ROUNDS),
    .LEN_BYTES   (LEN_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: shift registers, bit feed, length count, result register.
  tmac_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_data_byte  (in_data_byte),
    .cmd           (cmd),
    .out_tag       (out_tag),
    .out_tag_valid (out_tag_valid),
    .out_error     (out_error)
  );

endmodule

[design/tmac_ctrl.sv]
// Sequencing state machine for the TRIAD-MAC tag engine.
`timescale 1ns / 1ps

module tmac_ctrl
  import tmac_pkg::*;
#(
  parameter int PERM_ROUNDS = PERM_ROUNDS_DEF,
  parameter int LEN_BYTES   = LEN_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  output logic              out_valid,
  input  logic              out_stall,
  output tmac_cmd_t         cmd
);

  localparam int CNT_W = $clog2(PERM_ROUNDS > 64 ? PERM_ROUNDS : 64);
  localparam logic [CNT_W-1:0] PERM_LAST = CNT_W'(PERM_ROUNDS - 1);
  localparam logic [CNT_W-1:0] LEN_LAST  = CNT_W'(LEN_BYTES * 8 - 1);
  localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(7);
  localparam logic [CNT_W-1:0] SQZ_LAST  = CNT_W'(TAG_W - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_PRE   = 9'b000000100,
    S_DISP  = 9'b000001000,
    S_LEN   = 9'b000010000,
    S_ABS   = 9'b000100000,
    S_FPERM = 9'b001000000,
    S_SQZ   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  func_t            func_r, func_nxt;
  res_t             kind_r, kind_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last;

  assign last      = (cnt_r == '0);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    func_nxt      = func_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_ld = 1'b1;
          func_nxt    = func_t'(in_func);
          priority if (func_t'(in_func) == FUNC_NOP) begin
            kind_nxt  = RES_NONE;
            state_nxt = S_EMIT;
          end else if (func_t'(in_func) == FUNC_AD && phase_r == PH_MSG) begin
            kind_nxt  = RES_ERR;
            state_nxt = S_EMIT;
          end else if (phase_r == PH_IDLE) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DISP;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        phase_nxt = PH_AD;
        cnt_nxt   = PERM_LAST;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.step  = 1'b1;
        cmd.m_sel = (cnt_r == PERM_LAST) ? M_ONE : M_ZERO;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (func_r == FUNC_AD) begin
          cmd.feed_byte = 1'b1;
          cmd.cnt_inc   = 1'b1;
          cnt_nxt       = BYTE_LAST;
          state_nxt     = S_ABS;
        end else if (phase_r != PH_MSG) begin
          cmd.feed_len = 1'b1;
          cnt_nxt      = LEN_LAST;
          phase_nxt    = PH_MSG;
          state_nxt    = S_LEN;
        end else if (func_r == FUNC_MSG) begin
          cmd.feed_byte = 1'b1;
          cnt_nxt       = BYTE_LAST;
          state_nxt     = S_ABS;
        end else begin
          cnt_nxt   = PERM_LAST;
          state_nxt = S_FPERM;
        end
      end
      S_LEN: begin
        cmd.step  = 1'b1;
        cmd.m_sel = M_FEED;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          state_nxt = S_DISP;
        end
      end
      S_ABS: begin
        cmd.step  = 1'b1;
        cmd.m_sel = M_FEED;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          kind_nxt  = RES_NONE;
          state_nxt = S_EMIT;
        end
      end
      S_FPERM: begin
        cmd.step  = 1'b1;
        cmd.m_sel = (cnt_r == PERM_LAST) ? M_ONE : M_ZERO;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          cnt_nxt   = SQZ_LAST;
          state_nxt = S_SQZ;
        end
      end
      S_SQZ: begin
        cmd.step  = 1'b1;
        cmd.m_sel = M_ZERO;
        cmd.sqz   = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          kind_nxt    = RES_TAG;
          phase_nxt   = PH_IDLE;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.res_kind = kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    kind_r <= kind_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

[design/tmac_dp.sv]
// Shift-register state, key/nonce store, length counter and result register.
`timescale 1ns / 1ps

module tmac_dp
  import tmac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  tmac_cmd_t             cmd,
  output logic [TAG_W-1:0]      out_tag,
  output logic                  out_tag_valid,
  output logic                  out_error
);

  logic [KEY_HALF_W-1:0] key_low_r, key_high_r, nonce_low_r;
  logic [NONCE_HI_W-1:0] nonce_high_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic [REG_A_W:1]   a_r;
  logic [REG_BC_W:1]  b_r, c_r;
  logic [FEED_W-1:0]  feed_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [TAG_W-1:0]   tag_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic               out_tag_valid_r, out_error_r;

  logic [2*KEY_HALF_W-1:0]            key;
  logic [KEY_HALF_W+NONCE_HI_W-1:0]   nonce;
  logic [REG_A_W-1:0]                 a_bytes;
  logic [REG_BC_W-1:0]                b_bytes, c_bytes;
  logic m, t1, t2, t3, z, n1, n2, n3;

  assign key   = {key_high_r, key_low_r};
  assign nonce = {nonce_high_r, nonce_low_r};

  // First register: N0, K4, FF, K3, FF, K2, FF, K1, FE, K0 from byte 0 upward.
  assign a_bytes = {key[7:0], 8'hFE, key[15:8], 8'hFF, key[23:16], 8'hFF,
                    key[31:24], 8'hFF, key[39:32], nonce[7:0]};

  always_comb begin
    for (int i = 0; i < REG_BC_W / 8; i++) begin
      b_bytes[8*i +: 8] = nonce[8*(11-i) +: 8];
      c_bytes[8*i +: 8] = key[8*(15-i) +: 8];
    end
  end

  always_comb begin
    unique case (cmd.m_sel)
      M_ZERO:  m = 1'b0;
      M_ONE:   m = 1'b1;
      M_FEED:  m = feed_r[FEED_W-1];
      default: m = 1'b0;
    endcase
  end

  assign t1 = a_r[68] ^ a_r[80] ^ (b_r[85] & c_r[85]);
  assign t2 = b_r[64] ^ b_r[88];
  assign t3 = c_r[68] ^ c_r[88];
  assign z  = t1 ^ t2 ^ t3;
  assign n1 = t1 ^ (a_r[73] & a_r[79]) ^ b_r[66] ^ m;
  assign n2 = t2 ^ (b_r[65] & b_r[87]) ^ c_r[84] ^ m;
  assign n3 = t3 ^ (c_r[77] & c_r[87]) ^ a_r[74] ^ m;

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      nonce_low_r  <= '0;
      nonce_high_r <= '0;
      count_r      <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_KEY_LOW:    key_low_r    <= cfg_wdata;
          CFG_KEY_HIGH:   key_high_r   <= cfg_wdata;
          CFG_NONCE_LOW:  nonce_low_r  <= cfg_wdata;
          CFG_NONCE_HIGH: nonce_high_r <= cfg_wdata[NONCE_HI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_ld) begin
      byte_r <= in_data_byte;
    end
    if (cmd.load) begin
      a_r <= reg_a_from_bytes(a_bytes);
      b_r <= reg_bc_from_bytes(b_bytes);
      c_r <= reg_bc_from_bytes(c_bytes);
    end else if (cmd.step) begin
      a_r <= {a_r[REG_A_W-1:1], n3};
      b_r <= {b_r[REG_BC_W-1:1], n1};
      c_r <= {c_r[REG_BC_W-1:1], n2};
    end
    if (cmd.feed_byte) begin
      feed_r <= {byte_r, {(FEED_W-BYTE_W){1'b0}}};
    end else if (cmd.feed_len) begin
      feed_r <= feed_from_count(count_r);
    end else if (cmd.step && cmd.m_sel == M_FEED) begin
      feed_r <= {feed_r[FEED_W-2:0], 1'b0};
    end
    if (cmd.sqz) begin
      tag_r <= {tag_r[TAG_W-2:0], z};
    end
    if (cmd.out_ld) begin
      out_tag_r       <= (cmd.res_kind == RES_TAG) ? tag_r : '0;
      out_tag_valid_r <= (cmd.res_kind == RES_TAG);
      out_error_r     <= (cmd.res_kind == RES_ERR);
    end
  end

  assign out_tag       = out_tag_r;
  assign out_tag_valid = out_tag_valid_r;
  assign out_error     = out_error_r;

endmodule

[design/tmac_checker.sv]
// Port-level checker for the TRIAD-MAC tag engine, bound to the top level.
`timescale 1ns / 1ps

module tmac_checker
  import tmac_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TAG_W-1:0]  out_tag,
  input logic              out_tag_valid,
  input logic              out_error
);

  // A result is either a tag or an error, never both.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tag_valid && out_error))
    else $error("tag_valid and error both set");

  // Only a tag result carries a nonzero tag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tag_valid |-> out_tag == '0)
    else $error("nonzero tag without tag_valid");

  // The engine works on one request at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while busy");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_tag))
    else $error("stalled result changed");

endmodule

bind triad_mac_tag_engine_top tmac_checker u_tmac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tag       (out_tag),
  .out_tag_valid (out_tag_valid),
  .out_error     (out_error)
);

[test/tb_top.sv]
// Self-checking testbench for the TRIAD-MAC tag engine: directed and random requests.
`timescale 1ns / 1ps

module tb_top
  import tmac_pkg::*;
;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 8;
  localparam int          TAIL_CYCLES  = 200;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int          TARGET_REQS  = 2000;

  // One entry of the stimulus plan: a request, a register write, or a
  // pause until every outstanding result has come back.
  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t      kind;
    func_t           func;
    logic [7:0]      data;
    logic [2:0]      gap;
    cfg_idx_t        idx;
    logic [63:0]     wdata;
  } plan_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             tag_valid;
    logic             error;
  } mac_result_t;

  // Clock, reset and every block input start at known values.
  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  cfg_idx_t              cfg_index    = CFG_KEY_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  func_t                 in_func      = FUNC_AD;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_stall    = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [TAG_W-1:0]      out_tag;
  logic                  out_tag_valid;
  logic                  out_error;

  plan_item_t  cmd_plan[$];
  mac_result_t tag_results[$];
  logic [2:0]  gap_left  = '0;
  logic [2:0]  hold_left = '0;
  bit          tx_burst  = 1'b0;
  bit          rx_burst  = 1'b0;
  int          mismatch_count = 0;

  // Predictor copy of the engine: three shift registers indexed by tap
  // position (1 is the newest bit), the phase, the AD length and the
  // key/nonce registers as last written.
  logic [REG_A_W:1]        nfsr_a    = '0;
  logic [REG_BC_W:1]       nfsr_b    = '0;
  logic [REG_BC_W:1]       nfsr_c    = '0;
  phase_t                  mac_phase = PH_IDLE;
  logic [COUNT_W-1:0]      ad_len    = '0;
  logic [KEY_HALF_W-1:0]   key_lo    = '0;
  logic [KEY_HALF_W-1:0]   key_hi    = '0;
  logic [KEY_HALF_W-1:0]   nonce_lo  = '0;
  logic [NONCE_HI_W-1:0]   nonce_hi  = '0;

  triad_mac_tag_engine_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tag      (out_tag),
    .out_tag_valid(out_tag_valid),
    .out_error    (out_error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // One nonlinear update with input bit m; returns the keystream bit.
  function automatic logic triad_clock(input logic m);
    logic t1, t2, t3, z;
    t1 = nfsr_a[68] ^ nfsr_a[80] ^ (nfsr_b[85] & nfsr_c[85]);
    t2 = nfsr_b[64] ^ nfsr_b[88];
    t3 = nfsr_c[68] ^ nfsr_c[88];
    z  = t1 ^ t2 ^ t3;
    t1 = t1 ^ (nfsr_a[73] & nfsr_a[79]) ^ nfsr_b[66] ^ m;
    t2 = t2 ^ (nfsr_b[65] & nfsr_b[87]) ^ nfsr_c[84] ^ m;
    t3 = t3 ^ (nfsr_c[77] & nfsr_c[87]) ^ nfsr_a[74] ^ m;
    // Shift every bit one tap up; the new bit enters at tap 1.
    nfsr_a = {nfsr_a[REG_A_W-1:1], t3};
    nfsr_b = {nfsr_b[REG_BC_W-1:1], t1};
    nfsr_c = {nfsr_c[REG_BC_W-1:1], t2};
    return z;
  endfunction

  function automatic void triad_permute();
    logic unused;
    unused = triad_clock(1'b1);
    for (int i = 1; i < PERM_ROUNDS_DEF; i++) begin
      unused = triad_clock(1'b0);
    end
  endfunction

  // Feed a byte most significant bit first.
  function automatic void triad_absorb(input logic [7:0] b);
    logic unused;
    for (int j = 7; j >= 0; j--) begin
      unused = triad_clock(b[j]);
    end
  endfunction

  // Byte k of a register fills taps 8k+1..8k+8, bit 7 at the lowest tap.
  function automatic void triad_load();
    logic [127:0] kv;
    logic [95:0]  nv;
    logic [79:0]  ab;
    logic [7:0]   bb, cb;
    kv = {key_hi, key_lo};
    nv = {nonce_hi, nonce_lo};
    ab = {kv[7:0], 8'hFE, kv[15:8], 8'hFF, kv[23:16], 8'hFF, kv[31:24],
          8'hFF, kv[39:32], nv[7:0]};
    for (int k = 0; k < REG_A_W / 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        nfsr_a[8*k + 8 - j] = ab[8*k + j];
      end
    end
    for (int k = 0; k < REG_BC_W / 8; k++) begin
      bb = nv[8*(11 - k) +: 8];
      cb = kv[8*(15 - k) +: 8];
      for (int j = 0; j < 8; j++) begin
        nfsr_b[8*k + 8 - j] = bb[j];
        nfsr_c[8*k + 8 - j] = cb[j];
      end
    end
    triad_permute();
  endfunction

  // Advance the predictor by one accepted request and return its result.
  function automatic mac_result_t triad_step(input func_t f, input logic [7:0] d);
    mac_result_t r;
    logic [63:0] len_word;
    r = '0;
    if (f == FUNC_AD && mac_phase == PH_MSG) begin
      r.error = 1'b1;
    end else if (f != FUNC_NOP) begin
      if (mac_phase == PH_IDLE) begin
        triad_load();
        mac_phase = PH_AD;
      end
      if (f == FUNC_AD) begin
        triad_absorb(d);
        ad_len = ad_len + 1'b1;
      end else begin
        if (mac_phase != PH_MSG) begin
          len_word = 64'(ad_len);
          for (int k = 0; k < LEN_BYTES_DEF && k < 8; k++) begin
            triad_absorb(len_word[8*k +: 8]);
          end
          mac_phase = PH_MSG;
        end
        if (f == FUNC_MSG) begin
          triad_absorb(d);
        end else begin
          triad_permute();
          for (int i = 0; i < TAG_W; i++) begin
            r.tag = {r.tag[TAG_W-2:0], triad_clock(1'b0)};
          end
          r.tag_valid = 1'b1;
          mac_phase   = PH_IDLE;
          ad_len      = '0;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus plan builders
  // ---------------------------------------------------------------------

  task automatic push_request(input func_t f, input logic [7:0] d);
    plan_item_t p;
    p      = '0;
    p.kind = STEP_REQ;
    p.func = f;
    p.data = d;
    // Burst stretches send back to back; otherwise the gap is drawn at random.
    p.gap  = tx_burst ? 3'd0 : 3'($urandom_range(0, 7));
    cmd_plan.push_back(p);
  endtask

  task automatic push_write(input cfg_idx_t idx, input logic [63:0] v);
    plan_item_t p;
    p       = '0;
    p.kind  = STEP_CFG;
    p.idx   = idx;
    p.wdata = v;
    cmd_plan.push_back(p);
  endtask

  task automatic push_pause();
    plan_item_t p;
    p      = '0;
    p.kind = STEP_DRAIN;
    cmd_plan.push_back(p);
  endtask

  // Favor the extremes now and then, random words otherwise.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: drains cmd_plan one entry at a time. Hold the request payload
  // while stalled; register writes and pauses wait until every predicted
  // result has been collected so the engine is idle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    plan_item_t  e;
    mac_result_t r;
    logic        v_next;
    logic        we_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      gap_left <= '0;
    end else begin
      v_next  = in_valid;
      we_next = 1'b0;
      // Request accepted at this edge: predict its result right away so
      // ordering against config writes matches the engine.
      if (in_valid && !in_stall) begin
        r = triad_step(in_func, in_data_byte);
        tag_results.push_back(r);
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1'b1;
        end else if (cmd_plan.size() != 0) begin
          e = cmd_plan[0];
          case (e.kind)
            STEP_REQ: begin
              in_func      <= e.func;
              in_data_byte <= e.data;
              gap_left     <= e.gap;
              v_next        = 1'b1;
              void'(cmd_plan.pop_front());
            end
            STEP_CFG: begin
              if (tag_results.size() == 0) begin
                case (e.idx)
                  CFG_KEY_LOW:    key_lo   = e.wdata;
                  CFG_KEY_HIGH:   key_hi   = e.wdata;
                  CFG_NONCE_LOW:  nonce_lo = e.wdata;
                  CFG_NONCE_HIGH: nonce_hi = e.wdata[NONCE_HI_W-1:0];
                  default: ;
                endcase
                cfg_index <= e.idx;
                cfg_wdata <= e.wdata;
                we_next    = 1'b1;
                void'(cmd_plan.pop_front());
              end
            end
            default: begin
              // Pause: advance only once the engine has nothing in flight.
              if (tag_results.size() == 0) begin
                void'(cmd_plan.pop_front());
              end
            end
          endcase
        end
      end
      in_valid <= v_next;
      cfg_we   <= we_next;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare every field of each accepted result against the oldest
  // prediction, then draw how long to stall the next one (the stall counts
  // down only while a result is offered).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mac_result_t want;
    logic [2:0]  n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= '0;
    end else begin
      n = hold_left;
      if (out_valid && !out_stall) begin
        if (tag_results.size() == 0) begin
          note_mismatch("unexpected result", out_tag, '0);
        end else begin
          want = tag_results.pop_front();
          if (out_tag !== want.tag) begin
            note_mismatch("tag", out_tag, want.tag);
          end
          if (out_tag_valid !== want.tag_valid) begin
            note_mismatch("tag_valid", 64'(out_tag_valid), 64'(want.tag_valid));
          end
          if (out_error !== want.error) begin
            note_mismatch("error", 64'(out_error), 64'(want.error));
          end
        end
        n = rx_burst ? 3'd0 : 3'($urandom_range(0, 7));
        // Flip into or out of a no-stall stretch now and then.
        if ($urandom_range(0, 31) == 0) begin
          rx_burst = !rx_burst;
        end
      end else if (out_valid && n != 0) begin
        n = n - 1'b1;
      end
      hold_left <= n;
      out_stall <= (n != 0);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int counted;
    int shape;
    int n_ad;
    int n_msg;
    int n_noise;
    counted = 0;

    // Directed part. Registers are still at reset (all zero).
    push_request(FUNC_NOP, 8'hA5);      // unused selector at idle: no load
    push_request(FUNC_FIN, 8'hFF);      // finish with no bytes at all
    push_pause();
    push_write(CFG_KEY_LOW,    '1);
    push_write(CFG_KEY_HIGH,   '1);
    push_write(CFG_NONCE_LOW,  '1);
    push_write(CFG_NONCE_HIGH, '1);     // upper half must be dropped
    push_request(FUNC_AD,  8'h00);
    push_request(FUNC_AD,  8'hFF);
    push_request(FUNC_MSG, 8'h80);
    push_request(FUNC_MSG, 8'h01);
    push_request(FUNC_AD,  8'h5A);      // late associated data: error
    push_request(FUNC_NOP, 8'h00);      // unused selector mid-message
    push_request(FUNC_MSG, 8'hFF);
    push_request(FUNC_FIN, 8'h00);
    // A write in the middle of a message only counts at the next load.
    push_request(FUNC_AD,  8'h3C);
    push_pause();
    push_write(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    push_write(CFG_NONCE_HIGH, 64'h0000_0000_A5C3_0F96);
    push_request(FUNC_MSG, 8'h7E);
    push_request(FUNC_FIN, 8'h11);
    // Message straight into message bytes: zero AD length absorbed.
    push_request(FUNC_MSG, 8'h00);
    push_request(FUNC_MSG, 8'hC3);
    push_request(FUNC_FIN, 8'h00);
    push_pause();
    push_write(CFG_KEY_HIGH,  64'h5555_5555_5555_5555);
    push_write(CFG_NONCE_LOW, 64'hAAAA_AAAA_AAAA_AAAA);
    push_request(FUNC_AD,  8'h01);
    push_request(FUNC_FIN, 8'h00);      // finish right after AD

    // Random part: mostly well-formed messages with random content, some
    // noise and some messages cut short without a finish.
    while (counted < TARGET_REQS) begin
      if ($urandom_range(0, 7) == 0) begin
        push_pause();
        for (int i = 0; i < 4; i++) begin
          push_write(cfg_idx_t'(i), pick_word());
        end
      end else if ($urandom_range(0, 19) == 0) begin
        push_pause();
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      shape    = $urandom_range(0, 9);
      if (shape == 0) begin
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) begin
          push_request(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        n_ad  = $urandom_range(0, 8);
        n_msg = $urandom_range(0, 16);
        repeat (n_ad) begin
          push_request(FUNC_AD, 8'($urandom_range(0, 255)));
          counted++;
        end
        for (int i = 0; i < n_msg; i++) begin
          push_request(FUNC_MSG, 8'($urandom_range(0, 255)));
          counted++;
          if ($urandom_range(0, 39) == 0) begin
            push_request(FUNC_AD, 8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 39) == 0) begin
            push_request(FUNC_NOP, 8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 14) != 0) begin
          push_request(FUNC_FIN, 8'($urandom_range(0, 255)));
          counted++;
        end
      end
    end

    // Hold reset, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the plan to empty and every prediction to be matched.
    while (cmd_plan.size() != 0 || in_valid || tag_results.size() != 0) begin
      @(posedge clk);
    end
    // Give any stray result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[triad_mac_tag_engine_top.f]
design/tmac_pkg.sv
design/tmac_ctrl.sv
design/tmac_dp.sv
design/triad_mac_tag_engine_top.sv
design/tmac_checker.sv
test/tb_top.sv
